// ----- src/bvfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bit vector field access package
// Shared constants and types for the MSB-first bit vector field access unit.
// ----------------------------------------------------------------------------
package bvfa_pkg;

  // Depth of the byte store and the matching address width.
  localparam int unsigned MaxBytes = 64;
  localparam int unsigned AddrW    = $clog2(MaxBytes);

  // Longest field in bits and the pattern that the L/H padding forms follow.
  localparam int unsigned FieldMax   = 64;
  localparam logic [7:0]  PadPattern = 8'h2b;

  typedef enum logic [2:0] {
    OP_READ_FIELD  = 3'd0,
    OP_WRITE_FIELD = 3'd1,
    OP_SET_BIT     = 3'd2,
    OP_APPEND_BIT  = 3'd3,
    OP_GET_BIT     = 3'd4,
    OP_GET_LH      = 3'd5,
    OP_LOAD_BYTE   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    BIT_ZERO = 2'd0,
    BIT_ONE  = 2'd1,
    BIT_LOW  = 2'd2,
    BIT_HIGH = 2'd3
  } bit_code_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP
  } state_e;

endpackage

// ----- src/bit_vector_field_access_unit.sv -----
// ----------------------------------------------------------------------------
// Bit vector field access unit
// Byte store with a bit cursor; reads and writes MSB-first bit fields.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes through a fetch state and then one step
// per byte that the operation touches (1 to 9 for a 64-bit field, 1 for
// every other operation, zero-length fields and unused opcodes included);
// the result strobe is registered from the last step. The single byte-wide
// read-modify-write path walks the field one byte per cycle.
// A new item may be accepted in the cycle that shows the previous result.
// Reset: every byte reads as zero through per-byte valid bits (no clearing
// pass), the cursor is zero and the length register holds 64.
module bit_vector_field_access_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: number of bytes in use.
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_data_i,
  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [9:0]  bit_index_i,
  input  logic [6:0]  field_length_i,
  input  logic [63:0] write_value_i,
  input  logic [1:0]  bit_value_i,
  // Result channel, shown for exactly one cycle while done_o is high.
  output logic        done_o,
  output logic [63:0] read_value_o,
  output logic [1:0]  bit_result_o,
  output logic [10:0] next_index_o,
  output logic        status_o
);
  import bvfa_pkg::*;

  // Sequencer state and the working copy of the item.
  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [9:0]        idx_q, idx_d;
  logic [1:0]        bv_q, bv_d;
  logic [10:0]       pos_q, pos_d;
  logic [6:0]        rem_q, rem_d;
  logic [63:0]       acc_q, acc_d;
  logic [63:0]       wvs_q, wvs_d;
  logic [10:0]       cursor_q, cursor_d;
  logic [6:0]        bytes_q;

  // Registered result.
  logic              done_q, done_d;
  logic [63:0]       read_q, read_d;
  logic [1:0]        bres_q, bres_d;
  logic [10:0]       nxt_q, nxt_d;
  logic              status_q, status_d;

  // Byte store, its valid bits and the registered read port.
  logic [7:0]        mem [MaxBytes];
  logic [MaxBytes-1:0] valid_q;
  logic [7:0]        rd_data_q;
  logic              rd_valid_q;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic              wr_en;
  logic [7:0]        wr_data;

  // Step datapath signals.
  logic              accept, finish;
  logic [7:0]        eff_len;
  logic [7:0]        byte_cur;
  logic [2:0]        off;
  logic [3:0]        room, take;
  logic [7:0]        fmask, bmask, code_bits, placed;
  logic [7:0]        chunk;
  logic              in_rng, last;
  logic [10:0]       pos_n;
  logic [6:0]        len_sat;

  assign accept = start && (state_q == ST_IDLE);

  // The register may exceed the store depth; it is clamped to the depth.
  assign eff_len = ({1'b0, bytes_q} > 8'(MaxBytes)) ? 8'(MaxBytes) : {1'b0, bytes_q};

  // Bytes that were never written read as zero.
  assign byte_cur = rd_valid_q ? rd_data_q : 8'h00;
  assign off      = pos_q[2:0];
  assign room     = 4'd8 - {1'b0, off};
  assign take     = ({3'b000, room} > rem_q) ? rem_q[3:0] : room;
  assign last     = (rem_q == {3'b000, take});
  assign pos_n    = pos_q + {7'd0, take};

  // Field mask covers the bits of this byte that belong to the field.
  assign fmask  = (8'hff >> off) & ~(8'hff >> ({1'b0, off} + take));
  assign bmask  = 8'h80 >> off;
  // Write data sits at the top of the shifter, so a shift by the offset lines
  // it up with the field inside the byte.
  assign placed = (wvs_q[63:56] >> off) & fmask;
  assign chunk  = (byte_cur & fmask) >> (4'd8 - ({1'b0, off} + take));

  assign len_sat = (field_length_i > 7'(FieldMax)) ? 7'(FieldMax) : field_length_i;

  always_comb begin
    unique case (bit_code_e'(bv_q))
      BIT_ZERO: code_bits = 8'h00;
      BIT_ONE:  code_bits = bmask;
      BIT_LOW:  code_bits = PadPattern & bmask;
      BIT_HIGH: code_bits = ~PadPattern & bmask;
    endcase
  end

  // Load byte addresses whole bytes; everything else addresses bits.
  always_comb begin
    if (op_q == OP_LOAD_BYTE) begin
      in_rng = (idx_q < {2'b00, eff_len});
    end else begin
      in_rng = (pos_q[10:3] < eff_len);
    end
  end

  // Datapath: item capture, one byte per step, result formation.
  always_comb begin
    op_d     = op_q;
    idx_d    = idx_q;
    bv_d     = bv_q;
    pos_d    = pos_q;
    rem_d    = rem_q;
    acc_d    = acc_q;
    wvs_d    = wvs_q;
    cursor_d = cursor_q;
    finish   = 1'b0;
    wr_en    = 1'b0;
    wr_data  = byte_cur;
    read_d   = read_q;
    bres_d   = bres_q;
    nxt_d    = nxt_q;
    status_d = status_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = op_e'(opcode_i);
          idx_d = bit_index_i;
          bv_d  = bit_value_i;
          rem_d = len_sat;
          acc_d = '0;
          wvs_d = write_value_i << (7'(FieldMax) - len_sat);
          if (op_e'(opcode_i) == OP_APPEND_BIT) begin
            pos_d = cursor_q;
          end else begin
            pos_d = {1'b0, bit_index_i};
          end
        end
      end
      ST_FETCH: begin
      end
      ST_STEP: begin
        finish   = 1'b1;
        read_d   = '0;
        bres_d   = BIT_ZERO;
        nxt_d    = {1'b0, idx_q};
        status_d = 1'b0;
        unique case (op_q)
          OP_READ_FIELD, OP_WRITE_FIELD: begin
            if (rem_q == '0) begin
              cursor_d = pos_q;
              nxt_d    = pos_q;
            end else if (!in_rng) begin
              // Stop at the first byte out of range; earlier writes stay.
              cursor_d = pos_q;
              status_d = 1'b1;
            end else begin
              wr_en   = (op_q == OP_WRITE_FIELD);
              wr_data = (byte_cur & ~fmask) | placed;
              acc_d   = (acc_q << take) | {56'd0, chunk};
              wvs_d   = wvs_q << take;
              pos_d   = pos_n;
              rem_d   = rem_q - {3'b000, take};
              finish  = last;
              if (last) begin
                cursor_d = pos_n;
                nxt_d    = pos_n;
                if (op_q == OP_READ_FIELD) begin
                  read_d = acc_d;
                end
              end
            end
          end
          OP_SET_BIT, OP_APPEND_BIT: begin
            if (op_q == OP_APPEND_BIT) begin
              nxt_d = pos_q;
            end
            if (in_rng) begin
              wr_en   = 1'b1;
              wr_data = (byte_cur & ~bmask) | code_bits;
              if (op_q == OP_APPEND_BIT) begin
                cursor_d = pos_q + 11'd1;
                nxt_d    = pos_q + 11'd1;
              end
            end else begin
              status_d = 1'b1;
            end
          end
          OP_GET_BIT: begin
            if (in_rng) begin
              bres_d = ((byte_cur & bmask) != 8'h00) ? BIT_ONE : BIT_ZERO;
            end else begin
              status_d = 1'b1;
            end
          end
          OP_GET_LH: begin
            if (in_rng) begin
              bres_d = ((byte_cur & bmask) == (~PadPattern & bmask)) ? BIT_HIGH : BIT_LOW;
            end else begin
              status_d = 1'b1;
            end
          end
          OP_LOAD_BYTE: begin
            if (in_rng) begin
              wr_en   = 1'b1;
              wr_data = wvs_q[7:0];
            end else begin
              status_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // A load byte keeps its value unshifted: its length field plays no part,
  // so the shifter is bypassed by reloading the raw value at capture time.
  logic [63:0] wvs_cap;
  assign wvs_cap = (accept && (op_e'(opcode_i) == OP_LOAD_BYTE)) ? write_value_i : wvs_d;

  // Read the byte under the next position every cycle; the write hits the byte
  // under the current position (a load byte uses its index for both).
  always_comb begin
    if (op_q == OP_LOAD_BYTE) begin
      rd_addr = idx_q[AddrW-1:0];
      wr_addr = idx_q[AddrW-1:0];
    end else begin
      rd_addr = pos_d[3 +: AddrW];
      wr_addr = pos_q[3 +: AddrW];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_STEP;
      ST_STEP:  if (finish) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy   = (state_q != ST_IDLE);
    done_d = (state_q == ST_STEP) && finish;
  end

  assign done_o       = done_q;
  assign read_value_o = read_q;
  assign bit_result_o = bres_q;
  assign next_index_o = nxt_q;
  assign status_o     = status_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cursor_q <= '0;
      bytes_q  <= 7'd64;
      done_q   <= 1'b0;
      valid_q  <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        bytes_q <= cfg_data_i;
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    bv_q     <= bv_d;
    pos_q    <= pos_d;
    rem_q    <= rem_d;
    acc_q    <= acc_d;
    wvs_q    <= wvs_cap;
    read_q   <= read_d;
    bres_q   <= bres_d;
    nxt_q    <= nxt_d;
    status_q <= status_d;
  end

  // Byte store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q  <= mem[rd_addr];
    rd_valid_q <= valid_q[rd_addr] && !(wr_en && (wr_addr == rd_addr));
  end

  // A result is only shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result strobe while busy");

  // Every item needs a fetch and a step, so strobes never come back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

  // The store is only written while a step is in progress.
  a_write_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_STEP))
    else $error("store write outside a step");

  // An error result never carries field data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q) |-> (read_q == '0))
    else $error("error result with nonzero read value");

  // The bit count left never exceeds the longest field.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (rem_q <= 7'(FieldMax)))
    else $error("remaining bit count out of bounds");

endmodule
